>>> design/pme_pkg.sv
// Shared types, constants and helpers for the point Morton encoder.
// No dependencies; every other design file imports this package.
`default_nettype none
package pme_pkg;

    // Fixed-point and code geometry
    localparam int AXIS_BITS       = 21;
    localparam int COORD_FRAC_BITS = 16;
    localparam int SCALE_W         = 48;
    localparam int CODE_W          = 63;
    // 6 << (F+31) needs F+34 bits; quotient is kept at least one bit above the scale
    localparam int NUM_W           = COORD_FRAC_BITS + 34;
    localparam int QUOT_W          = (NUM_W > SCALE_W) ? NUM_W : SCALE_W + 1;
    localparam int QCNT_W          = $clog2(QUOT_W);
    localparam int ENC_SHIFT       = COORD_FRAC_BITS + 7;

    localparam logic [QUOT_W-1:0]  SCALE_NUM = QUOT_W'(6) << (COORD_FRAC_BITS + 31);
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam logic [63:0]        SQ_NONE   = '1;
    localparam logic [63:0]        SQ_SAT    = 64'hffff_ffff_ffff_fffe;

    // Request mode codes
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_MEASURE = 2'd1;
    localparam logic [1:0] MODE_ENCODE  = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_ENCODE  = 2'd2
    } pme_op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pme_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] morton_code;
        logic              out_of_range;
    } pme_out_t;

    // Classified request held in the front queue
    typedef struct packed {
        pme_op_t     op;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } pme_cmd_t;

    typedef struct packed {
        logic        start;
        logic [63:0] min_sq;
    } pme_sc_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] scale;
    } pme_sc_rsp_t;

    // Place field bit i at code bit 3i
    function automatic logic [CODE_W-1:0] pme_spread(input logic [AXIS_BITS-1:0] f);
        logic [CODE_W-1:0] r;
        r = '0;
        for (int i = 0; i < AXIS_BITS; i++) begin
            r[3*i] = f[i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/pme_front.sv
// Front end: accepts requests, classifies the mode and queues them (2 entries).
// Depends on pme_pkg.
`default_nettype none
module pme_front
    import pme_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pme_in_t  s_data,
    output logic          q_valid,
    output pme_cmd_t      q_cmd,
    input  wire logic     q_pop
);

    pme_cmd_t   cmd_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept, push, pop;
    pme_op_t    op;

    assign s_ready = (cnt_reg != 2'd2);
    assign accept  = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = cmd_reg[rd_ptr_reg];
    assign pop     = q_valid && q_pop;

    // Classify; the unused mode is dropped here
    always_comb begin
        push = accept;
        op   = OP_CLEAR;
        case (s_data.mode)
            MODE_CLEAR:   op = OP_CLEAR;
            MODE_MEASURE: op = OP_MEASURE;
            MODE_ENCODE:  op = OP_ENCODE;
            default:      push = 1'b0;
        endcase
    end

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg[wr_ptr_reg] <= '{op: op, pos_x: s_data.pos_x,
                                     pos_y: s_data.pos_y, pos_z: s_data.pos_z};
        end
    end

endmodule
`default_nettype wire

>>> design/pme_scale.sv
// Scale unit: floor(sqrt(min)) by bit pairs, then restoring divide of 6<<(F+31) by 5r.
// Depends on pme_pkg.
`default_nettype none
module pme_scale
    import pme_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire pme_sc_req_t req,
    output pme_sc_rsp_t      rsp
);

    typedef enum logic [4:0] {
        SC_IDLE = 5'b00001,
        SC_ROOT = 5'b00010,
        SC_DSET = 5'b00100,
        SC_DIV  = 5'b01000,
        SC_FIN  = 5'b10000
    } sc_state_t;

    sc_state_t          state_reg, state_next;
    logic [63:0]        op_reg, op_next;
    logic [63:0]        res_reg, res_next;
    logic [63:0]        one_reg, one_next;
    logic [34:0]        den_reg, den_next;
    logic [35:0]        rem_reg, rem_next;
    logic [QUOT_W-1:0]  num_reg, num_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [63:0]        trial;
    logic [35:0]        rem_sh;
    logic [31:0]        root;

    assign rsp   = '{done: done_reg, scale: scale_reg};
    assign trial = res_reg + one_reg;
    assign rem_sh = {rem_reg[34:0], num_reg[QUOT_W-1]};
    assign root  = res_reg[31:0];

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        one_next   = one_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        scale_next = scale_reg;
        case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    if (req.min_sq == SQ_NONE) begin
                        scale_next = '0;
                        done_next  = 1'b1;
                    end else begin
                        op_next    = req.min_sq;
                        res_next   = '0;
                        one_next   = 64'd1 << 62;
                        state_next = SC_ROOT;
                    end
                end
            end
            // One result bit per cycle
            SC_ROOT: begin
                if (op_reg >= trial) begin
                    op_next  = op_reg - trial;
                    res_next = (res_reg >> 1) + one_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                one_next = one_reg >> 2;
                if (one_reg == 64'd1) begin
                    state_next = SC_DSET;
                end
            end
            SC_DSET: begin
                if (root == 32'd0) begin
                    scale_next = SCALE_MAX;
                    done_next  = 1'b1;
                    state_next = SC_IDLE;
                end else begin
                    den_next   = {1'b0, root, 2'b00} + {3'b000, root};
                    rem_next   = '0;
                    num_next   = SCALE_NUM;
                    quot_next  = '0;
                    cnt_next   = QCNT_W'(QUOT_W - 1);
                    state_next = SC_DIV;
                end
            end
            // One quotient bit per cycle
            SC_DIV: begin
                num_next = num_reg << 1;
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next  = rem_sh - {1'b0, den_reg};
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = SC_FIN;
                end
            end
            SC_FIN: begin
                if (quot_reg[QUOT_W-1:SCALE_W] != '0) begin
                    scale_next = SCALE_MAX;
                end else begin
                    scale_next = quot_reg[SCALE_W-1:0];
                end
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        res_reg   <= res_next;
        one_reg   <= one_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        scale_reg <= scale_next;
    end

endmodule
`default_nettype wire

>>> design/pme_back.sv
// Back end: measure and encode sequencer with one shared 32x32 multiplier and output register.
// Depends on pme_pkg; drives the pme_scale unit through its request/response structs.
`default_nettype none
module pme_back
    import pme_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire pme_cmd_t    q_cmd,
    output logic             q_pop,
    output pme_sc_req_t      sc_req,
    input  wire pme_sc_rsp_t sc_rsp,
    output logic             m_valid,
    input  wire logic        m_ready,
    output pme_out_t         m_data
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_M_MUL = 11'b00000000010,
        ST_M_ACC = 11'b00000000100,
        ST_M_UPD = 11'b00000001000,
        ST_S_GO  = 11'b00000010000,
        ST_S_WT  = 11'b00000100000,
        ST_E_LO  = 11'b00001000000,
        ST_E_HI  = 11'b00010000000,
        ST_E_FIN = 11'b00100000000,
        ST_E_OUT = 11'b01000000000,
        ST_E_CHK = 11'b10000000000
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic [31:0]        cur_reg [3];
    logic [31:0]        prev_reg [3];
    logic               have_prev_reg, have_prev_next;
    logic [63:0]        min_sq_reg, min_sq_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic               scale_ok_reg, scale_ok_next;
    logic [1:0]         axis_reg, axis_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;
    logic [AXIS_BITS-1:0] field_reg [3];
    logic               bad_reg, bad_next;
    logic               m_valid_reg, m_valid_next;
    pme_out_t           m_data_reg;
    logic               load_cur, load_prev, clear_all, out_load, field_we;

    logic [31:0]        cur, prv, abs_v, mul_a, mul_b;
    logic [32:0]        diff, mag;
    logic [63:0]        product;
    logic [64:0]        acc_sum;
    logic [56:0]        enc_sum, enc_m;
    logic [56:0]        lim;
    logic               neg, bad_ax;
    logic [AXIS_BITS-1:0] field_v;
    logic [CODE_W-1:0]  code;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign sc_req  = '{start: (state_reg == ST_S_GO), min_sq: min_sq_reg};

    // Axis operands and the shared multiplier
    assign cur   = cur_reg[axis_reg];
    assign prv   = prev_reg[axis_reg];
    assign diff  = {cur[31], cur} - {prv[31], prv};
    assign mag   = diff[32] ? (~diff + 33'd1) : diff;
    assign neg   = cur[31];
    assign abs_v = neg ? (~cur + 32'd1) : cur;

    always_comb begin
        mul_a = abs_v;
        mul_b = {8'd0, scale_reg[23:0]};
        if (state_reg == ST_M_MUL) begin
            mul_a = mag[31:0];
            mul_b = mag[31:0];
        end else if (state_reg == ST_E_HI) begin
            mul_b = {8'd0, scale_reg[47:24]};
        end
    end
    assign product = mul_a * mul_b;

    // Saturating distance sum
    assign acc_sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    // Scaled coordinate and range check
    assign enc_sum = {1'b0, prod_reg[55:0]} + {25'd0, acc_reg[31:0]};
    assign enc_m   = enc_sum >> ENC_SHIFT;
    assign lim     = 57'd1 << (AXIS_BITS - 1);
    assign bad_ax  = neg ? (enc_m > lim) : (enc_m >= lim);
    assign field_v = neg ? AXIS_BITS'(~enc_m + 57'd1) : enc_m[AXIS_BITS-1:0];

    assign code = pme_spread(field_reg[0]) | (pme_spread(field_reg[1]) << 1)
                | (pme_spread(field_reg[2]) << 2);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        min_sq_next    = min_sq_reg;
        scale_next     = scale_reg;
        scale_ok_next  = scale_ok_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        q_pop          = 1'b0;
        load_cur       = 1'b0;
        load_prev      = 1'b0;
        clear_all      = 1'b0;
        out_load       = 1'b0;
        field_we       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    load_cur  = 1'b1;
                    axis_next = 2'd0;
                    acc_next  = '0;
                    bad_next  = 1'b0;
                    case (q_cmd.op)
                        OP_CLEAR: clear_all = 1'b1;
                        OP_MEASURE: begin
                            if (have_prev_reg) begin
                                state_next = ST_M_MUL;
                            end else begin
                                state_next = ST_M_UPD;
                            end
                        end
                        OP_ENCODE: begin
                            state_next = scale_ok_reg ? ST_E_LO : ST_S_GO;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_M_MUL: begin
                prod_next  = product;
                state_next = ST_M_ACC;
            end
            ST_M_ACC: begin
                acc_next = (acc_sum >= {1'b0, SQ_NONE}) ? SQ_SAT : acc_sum[63:0];
                if (axis_reg == 2'd2) begin
                    state_next = ST_M_UPD;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_M_MUL;
                end
            end
            ST_M_UPD: begin
                if (have_prev_reg && acc_reg != '0 && acc_reg < min_sq_reg) begin
                    min_sq_next = acc_reg;
                end
                load_prev      = 1'b1;
                have_prev_next = 1'b1;
                scale_ok_next  = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_S_GO: state_next = ST_S_WT;
            ST_S_WT: begin
                if (sc_rsp.done) begin
                    scale_next    = sc_rsp.scale;
                    scale_ok_next = 1'b1;
                    state_next    = ST_E_LO;
                end
            end
            ST_E_LO: begin
                prod_next  = product;
                state_next = ST_E_HI;
            end
            ST_E_HI: begin
                acc_next   = {32'd0, prod_reg[55:24]};
                prod_next  = product;
                state_next = ST_E_FIN;
            end
            ST_E_FIN: begin
                field_we   = 1'b1;
                bad_next   = bad_reg | bad_ax;
                state_next = ST_E_CHK;
            end
            ST_E_CHK: begin
                if (axis_reg == 2'd2) begin
                    state_next = ST_E_OUT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_E_LO;
                end
            end
            ST_E_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (clear_all) begin
            have_prev_next = 1'b0;
            min_sq_next    = SQ_NONE;
            scale_next     = '0;
            scale_ok_next  = 1'b0;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            min_sq_reg    <= SQ_NONE;
            scale_reg     <= '0;
            scale_ok_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            min_sq_reg    <= min_sq_next;
            scale_reg     <= scale_next;
            scale_ok_reg  <= scale_ok_next;
            m_valid_reg   <= m_valid_next;
            for (int i = 0; i < 3; i++) begin
                if (clear_all) begin
                    prev_reg[i] <= '0;
                end else if (load_prev) begin
                    prev_reg[i] <= cur_reg[i];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        axis_reg <= axis_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        bad_reg  <= bad_next;
        if (load_cur) begin
            cur_reg[0] <= q_cmd.pos_x;
            cur_reg[1] <= q_cmd.pos_y;
            cur_reg[2] <= q_cmd.pos_z;
        end
        if (field_we) begin
            field_reg[axis_reg] <= field_v;
        end
        if (out_load) begin
            m_data_reg.morton_code  <= bad_reg ? '0 : code;
            m_data_reg.out_of_range <= bad_reg;
        end
    end

endmodule
`default_nettype wire

>>> design/point_morton_encoder_core.sv
// Top level of the point Morton encoder: front queue, back sequencer, scale unit.
// Depends on pme_pkg, pme_front, pme_back and pme_scale.
//
//   Channel  Ports                      Moves
//   s_       s_valid s_ready s_data     request: mode, pos_x, pos_y, pos_z
//   m_       m_valid m_ready m_data     result: morton_code, out_of_range
//
// Back end: clear acts in idle; measure multiplies and accumulates each axis,
// then updates (the first point updates directly). Encode forms the scale if
// needed (0 if no distance, else bit-pair root, one quotient bit per cycle).
// The shared multiplier runs once per cycle; each axis takes its own steps.
// Reset (aresetn low, synchronous) empties the queue and resets control state.
// A 2-entry queue takes requests while the back end works or m_ stalls.
`default_nettype none
module point_morton_encoder_core
    import pme_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire pme_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output pme_out_t     m_data
);

    logic        q_valid;
    logic        q_pop;
    pme_cmd_t    q_cmd;
    pme_sc_req_t sc_req;
    pme_sc_rsp_t sc_rsp;

    pme_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    pme_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sc_req),
        .rsp     (sc_rsp)
    );

    pme_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .sc_req  (sc_req),
        .sc_rsp  (sc_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
